@@ hw/rtl/rss_pkg.sv @@
package rss_pkg;

    localparam int COUNTER_BITS = 48;

    localparam int LEN_W      = 17;
    localparam int BYTE_W     = 8;
    localparam int SEQ_W      = 16;
    localparam int TS_W       = 32;
    localparam int TIME_W     = 64;
    localparam int OUT_CNT_W  = 48;
    localparam int PT_W       = 7;
    localparam int HIST_DEPTH = 1 << PT_W;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [LEN_W-1:0] MIN_HEADER_BYTES = LEN_W'(12);
    localparam logic [1:0]       RTP_VERSION      = 2'd2;
    localparam int               MARKER_POS       = 7;
    localparam logic [SEQ_W-1:0] GAP_LIMIT        = SEQ_W'((1 << SEQ_W) / 2 - 1);

    localparam int SUM_W = ((COUNTER_BITS > LEN_W) ? COUNTER_BITS : LEN_W) + 1;

    typedef logic [COUNTER_BITS-1:0] t_count;
    localparam t_count COUNT_MAX = '1;

    // one classified packet, front to back
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] now;
        logic              hdr_valid;
        logic [PT_W-1:0]   pt;
        logic              marker;
        logic [SEQ_W-1:0]  gap;
        logic              gap_add;
        logic              frame_new;
    } t_cmd;

    function automatic t_count sat_add(t_count a, logic [LEN_W-1:0] b);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(a) + SUM_W'(b);
        if (sum > SUM_W'(COUNT_MAX)) begin
            return COUNT_MAX;
        end
        return sum[COUNTER_BITS-1:0];
    endfunction

    function automatic logic [OUT_CNT_W-1:0] to_out(t_count v);
        logic [TIME_W-1:0] w;
        w = TIME_W'(v);
        return w[OUT_CNT_W-1:0];
    endfunction

endpackage

@@ hw/rtl/rss_if.sv @@
interface rss_in_if import rss_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LEN_W-1:0]   packet_length;
    logic [BYTE_W-1:0]  header_byte0;
    logic [BYTE_W-1:0]  header_byte1;
    logic [SEQ_W-1:0]   sequence_number;
    logic [TS_W-1:0]    rtp_timestamp;
    logic [TIME_W-1:0]  arrival_time_us;

    modport source (output valid, packet_length, header_byte0, header_byte1,
                    sequence_number, rtp_timestamp, arrival_time_us, input ready);
    modport sink   (input valid, packet_length, header_byte0, header_byte1,
                    sequence_number, rtp_timestamp, arrival_time_us, output ready);
endinterface

interface rss_out_if import rss_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OUT_CNT_W-1:0] total_packets;
    logic [OUT_CNT_W-1:0] total_bytes;
    logic [OUT_CNT_W-1:0] total_frames;
    logic [OUT_CNT_W-1:0] total_seq_gaps;
    logic [OUT_CNT_W-1:0] type_packet_count;
    logic                 header_valid;
    logic [TIME_W-1:0]    max_spread_us;
    logic [TIME_W-1:0]    peak_marker_gap_us;
    logic [TIME_W-1:0]    first_arrival_us;
    logic [TIME_W-1:0]    last_arrival_us;

    modport source (output valid, total_packets, total_bytes, total_frames,
                    total_seq_gaps, type_packet_count, header_valid, max_spread_us,
                    peak_marker_gap_us, first_arrival_us, last_arrival_us,
                    input ready);
    modport sink   (input valid, total_packets, total_bytes, total_frames,
                    total_seq_gaps, type_packet_count, header_valid, max_spread_us,
                    peak_marker_gap_us, first_arrival_us, last_arrival_us,
                    output ready);
endinterface

@@ hw/rtl/rss_ram.sv @@
module rss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/rss_front.sv @@
module rss_front import rss_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rss_in_if.sink    i_pkt,
    input  logic      i_fifo_ready,
    output logic      o_push,
    output t_cmd      o_cmd
);

    logic             r_seq_seen;
    logic             r_frame_open;
    logic [SEQ_W-1:0] r_prev_seq;
    logic [TS_W-1:0]  r_frame_stamp;

    logic             hdr_valid;
    logic             marker;
    logic             frame_new;
    logic [SEQ_W-1:0] expected;
    logic [SEQ_W-1:0] gap;
    logic             accept;

    assign i_pkt.ready = i_fifo_ready;
    assign accept      = i_pkt.valid && i_fifo_ready;

    assign hdr_valid = (i_pkt.packet_length >= MIN_HEADER_BYTES)
                       && (i_pkt.header_byte0[7:6] == RTP_VERSION);
    assign marker    = i_pkt.header_byte1[MARKER_POS];
    assign expected  = r_prev_seq + SEQ_W'(1);
    assign gap       = i_pkt.sequence_number - expected;
    assign frame_new = hdr_valid
                       && (!r_frame_open || (i_pkt.rtp_timestamp != r_frame_stamp));

    always_comb begin
        o_cmd.len       = i_pkt.packet_length;
        o_cmd.now       = i_pkt.arrival_time_us;
        o_cmd.hdr_valid = hdr_valid;
        o_cmd.pt        = i_pkt.header_byte1[PT_W-1:0];
        o_cmd.marker    = marker;
        o_cmd.gap       = gap;
        o_cmd.gap_add   = hdr_valid && r_seq_seen && (gap < GAP_LIMIT);
        o_cmd.frame_new = frame_new;
    end

    assign o_push = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_seen   <= 1'b0;
            r_frame_open <= 1'b0;
        end else if (accept && hdr_valid) begin
            r_seq_seen   <= 1'b1;
            // a marker closes the frame; otherwise it is open from here on
            r_frame_open <= !marker;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && hdr_valid) begin
            r_prev_seq <= i_pkt.sequence_number;
            if (frame_new) begin
                r_frame_stamp <= i_pkt.rtp_timestamp;
            end
        end
    end

endmodule

@@ hw/rtl/rss_fifo.sv @@
module rss_fifo import rss_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);

    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_ready = (r_count != FIFO_CNT_W'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [FIFO_PTR_W-1:0] ptr_inc(logic [FIFO_PTR_W-1:0] p);
        return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + FIFO_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - FIFO_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> !i_push)
        else $error("push into full queue");

endmodule

@@ hw/rtl/rss_back.sv @@
module rss_back import rss_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    rss_out_if.source o_stat
);

    // stage 1: item popped, histogram read in flight
    logic              r_s1_valid;
    t_cmd              r_s1;
    logic              r_fwd_hit;
    t_count            r_fwd_val;

    logic [HIST_DEPTH-1:0] r_hist_vld;
    logic [COUNTER_BITS-1:0] ram_rdata;

    t_count            r_pkt_cnt;
    t_count            r_byte_cnt;
    t_count            r_frame_cnt;
    t_count            r_gap_cnt;
    logic [TIME_W-1:0] r_first;
    logic [TIME_W-1:0] r_start;
    logic [TIME_W-1:0] r_spread;
    logic [TIME_W-1:0] r_last_mark;
    logic [TIME_W-1:0] r_mgap;

    logic              r_out_valid;

    logic              fire;
    logic              mark;
    t_count            hist_base;
    t_count            n_hist;
    t_count            n_pkt_cnt;
    t_count            n_byte_cnt;
    t_count            n_frame_cnt;
    t_count            n_gap_cnt;
    logic [TIME_W-1:0] n_first;
    logic [TIME_W-1:0] n_start;
    logic [TIME_W-1:0] n_spread;
    logic [TIME_W-1:0] n_last_mark;
    logic [TIME_W-1:0] n_mgap;
    logic [TIME_W-1:0] spread;
    logic [TIME_W-1:0] mgap;

    assign fire  = r_s1_valid && (!r_out_valid || o_stat.ready);
    assign o_pop = i_cmd_valid && (!r_s1_valid || fire);
    assign mark  = r_s1.hdr_valid && r_s1.marker;

    rss_ram #(
        .WIDTH (COUNTER_BITS),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (fire && r_s1.hdr_valid),
        .i_waddr (r_s1.pt),
        .i_wdata (n_hist),
        .i_re    (o_pop),
        .i_raddr (i_cmd.pt),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        // the write issued in the cycle of our read is not in ram_rdata
        if (r_fwd_hit) begin
            hist_base = r_fwd_val;
        end else if (r_hist_vld[r_s1.pt]) begin
            hist_base = ram_rdata;
        end else begin
            hist_base = '0;
        end
        n_hist      = sat_add(hist_base, LEN_W'(1));
        n_pkt_cnt   = sat_add(r_pkt_cnt, LEN_W'(1));
        n_byte_cnt  = sat_add(r_byte_cnt, r_s1.len);
        n_frame_cnt = mark ? sat_add(r_frame_cnt, LEN_W'(1)) : r_frame_cnt;
        n_gap_cnt   = r_s1.gap_add ? sat_add(r_gap_cnt, LEN_W'(r_s1.gap)) : r_gap_cnt;
        n_first     = (r_first == '0) ? r_s1.now : r_first;
        n_start     = r_s1.frame_new ? r_s1.now : r_start;
        spread      = r_s1.now - n_start;
        mgap        = r_s1.now - r_last_mark;
        n_spread    = (mark && (spread > r_spread)) ? spread : r_spread;
        n_mgap      = (mark && (r_last_mark != '0) && (mgap > r_mgap)) ? mgap : r_mgap;
        n_last_mark = mark ? r_s1.now : r_last_mark;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_out_valid <= 1'b0;
            r_hist_vld  <= '0;
            r_pkt_cnt   <= '0;
            r_byte_cnt  <= '0;
            r_frame_cnt <= '0;
            r_gap_cnt   <= '0;
            r_first     <= '0;
            r_start     <= '0;
            r_spread    <= '0;
            r_last_mark <= '0;
            r_mgap      <= '0;
        end else begin
            if (o_pop) begin
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= fire && r_s1.hdr_valid && (i_cmd.pt == r_s1.pt);
            end else if (fire) begin
                r_s1_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_stat.ready) begin
                r_out_valid <= 1'b0;
            end
            if (fire) begin
                if (r_s1.hdr_valid) begin
                    r_hist_vld[r_s1.pt] <= 1'b1;
                end
                r_pkt_cnt   <= n_pkt_cnt;
                r_byte_cnt  <= n_byte_cnt;
                r_frame_cnt <= n_frame_cnt;
                r_gap_cnt   <= n_gap_cnt;
                r_first     <= n_first;
                r_start     <= n_start;
                r_spread    <= n_spread;
                r_last_mark <= n_last_mark;
                r_mgap      <= n_mgap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1      <= i_cmd;
            r_fwd_val <= n_hist;
        end
        if (fire) begin
            o_stat.total_packets      <= to_out(n_pkt_cnt);
            o_stat.total_bytes        <= to_out(n_byte_cnt);
            o_stat.total_frames       <= to_out(n_frame_cnt);
            o_stat.total_seq_gaps     <= to_out(n_gap_cnt);
            o_stat.type_packet_count  <= r_s1.hdr_valid ? to_out(n_hist) : '0;
            o_stat.header_valid       <= r_s1.hdr_valid;
            o_stat.max_spread_us      <= n_spread;
            o_stat.peak_marker_gap_us <= n_mgap;
            o_stat.first_arrival_us   <= n_first;
            o_stat.last_arrival_us    <= r_s1.now;
        end
    end

    assign o_stat.valid = r_out_valid;

    a_fire_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("result lost at output register");

    a_out_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_pkt_cnt != '0))
        else $error("result shown with zero packet count");

    a_pkt_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_pkt_cnt >= $past(r_pkt_cnt)))
        else $error("packet count went down");

endmodule

@@ hw/rtl/rtp_stream_statistics.sv @@
// RTP receive statistics.
// i_pkt carries one received packet per item: length, first two header
// bytes, sequence number, RTP timestamp and arrival time. o_stat returns one
// item per packet with the running totals, the histogram count of the
// packet's payload type, the header-valid flag, the largest frame spread,
// the largest marker-to-marker gap and the first and last arrival times.
// Both channels use valid/ready; an item moves when both are high.
// An accepted packet passes the queue, the stage 1 register and the output
// register on its way to o_stat. Throughput is one packet per cycle while
// o_stat is ready; the histogram read-modify-write in the back stage sets it,
// with the write of the previous packet forwarded. A 2-entry queue splits the
// classifier from the statistics stage, and an output register lets input keep flowing while one result waits.
// When o_stat stalls, the back stage and then the queue fill, and i_pkt.ready
// drops once up to 3 items are held behind the waiting result.
// Reset clears all counters, times and the 128 histogram valid bits at once;
// there is no clearing pass, and items are taken on the first cycle after.
module rtp_stream_statistics import rss_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rss_in_if.sink    i_pkt,
    rss_out_if.source o_stat
);

    logic fifo_ready;
    logic push;
    t_cmd push_cmd;
    logic pop;
    logic cmd_valid;
    t_cmd cmd;

    rss_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pkt        (i_pkt),
        .i_fifo_ready (fifo_ready),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    rss_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_ready (fifo_ready),
        .i_pop   (pop),
        .o_valid (cmd_valid),
        .o_data  (cmd)
    );

    rss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .o_stat      (o_stat)
    );

endmodule

@@ dv/rss_stats_checker.sv @@
module rss_stats_checker import rss_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rss_in_if           i_pkt,
    rss_out_if          i_stat,
    output int unsigned o_mismatches,
    output int unsigned o_pending,
    output int unsigned o_checked,
    output int unsigned o_valid_headers,
    output int unsigned o_markers
);

    typedef struct {
        logic [OUT_CNT_W-1:0] total_packets;
        logic [OUT_CNT_W-1:0] total_bytes;
        logic [OUT_CNT_W-1:0] total_frames;
        logic [OUT_CNT_W-1:0] total_seq_gaps;
        logic [OUT_CNT_W-1:0] type_packet_count;
        logic                 header_valid;
        logic [TIME_W-1:0]    max_spread_us;
        logic [TIME_W-1:0]    peak_marker_gap_us;
        logic [TIME_W-1:0]    first_arrival_us;
        logic [TIME_W-1:0]    last_arrival_us;
    } t_stat;

    // running statistics as the block should hold them
    t_count            pkt_cnt;
    t_count            byte_cnt;
    t_count            frame_cnt;
    t_count            gap_cnt;
    t_count            type_hist [HIST_DEPTH];
    logic [TIME_W-1:0] first_t;
    logic [TIME_W-1:0] last_t;
    logic [TIME_W-1:0] frame_start_t;
    logic [TIME_W-1:0] max_spread;
    logic [TIME_W-1:0] last_marker_t;
    logic [TIME_W-1:0] max_marker_gap;
    logic [TS_W-1:0]   cur_frame_stamp;
    logic [SEQ_W-1:0]  prev_seq;
    logic              in_frame;
    logic              seq_seen;

    t_stat       expected_stats [$];
    int unsigned fault_count;
    int unsigned result_index;
    int unsigned valid_headers;
    int unsigned marker_packets;

    function automatic t_count add_sat(t_count a, logic [63:0] b);
        logic [64:0] sum;
        sum = {1'b0, 64'(a)} + {1'b0, b};
        if (sum > 65'(COUNT_MAX)) begin
            return COUNT_MAX;
        end
        return t_count'(sum);
    endfunction

    function automatic t_stat account_packet(logic [LEN_W-1:0] len, logic [BYTE_W-1:0] b0,
                                             logic [BYTE_W-1:0] b1, logic [SEQ_W-1:0] seq,
                                             logic [TS_W-1:0] ts, logic [TIME_W-1:0] now);
        t_stat             r;
        logic              hv;
        logic [PT_W-1:0]   pt;
        logic [SEQ_W-1:0]  gap;
        logic [TIME_W-1:0] spread;
        logic [TIME_W-1:0] mgap;
        pkt_cnt  = add_sat(pkt_cnt, 64'd1);
        byte_cnt = add_sat(byte_cnt, 64'(len));
        if (first_t == '0) begin
            first_t = now;
        end
        last_t = now;
        hv = (len >= MIN_HEADER_BYTES) && (b0[7:6] == RTP_VERSION);
        r.type_packet_count = '0;
        if (hv) begin
            valid_headers++;
            pt = b1[PT_W-1:0];
            type_hist[pt] = add_sat(type_hist[pt], 64'd1);
            r.type_packet_count = OUT_CNT_W'(type_hist[pt]);
            if (seq_seen) begin
                gap = seq - prev_seq - SEQ_W'(1);
                // big forward jumps are reorders or duplicates
                if (gap < GAP_LIMIT) begin
                    gap_cnt = add_sat(gap_cnt, 64'(gap));
                end
            end
            prev_seq = seq;
            seq_seen = 1'b1;
            if (!in_frame || ts != cur_frame_stamp) begin
                cur_frame_stamp = ts;
                frame_start_t   = now;
                in_frame        = 1'b1;
            end
            if (b1[MARKER_POS]) begin
                marker_packets++;
                spread    = now - frame_start_t;
                frame_cnt = add_sat(frame_cnt, 64'd1);
                if (spread > max_spread) begin
                    max_spread = spread;
                end
                // zero marker time means no marker seen yet
                if (last_marker_t != '0) begin
                    mgap = now - last_marker_t;
                    if (mgap > max_marker_gap) begin
                        max_marker_gap = mgap;
                    end
                end
                last_marker_t = now;
                in_frame      = 1'b0;
            end
        end
        r.total_packets      = OUT_CNT_W'(pkt_cnt);
        r.total_bytes        = OUT_CNT_W'(byte_cnt);
        r.total_frames       = OUT_CNT_W'(frame_cnt);
        r.total_seq_gaps     = OUT_CNT_W'(gap_cnt);
        r.header_valid       = hv;
        r.max_spread_us      = max_spread;
        r.peak_marker_gap_us = max_marker_gap;
        r.first_arrival_us   = first_t;
        r.last_arrival_us    = last_t;
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
        if (act !== exp) begin
            fault_count++;
            if (fault_count <= 10) begin
                $display("result %0d: %s expected %h, got %h", result_index, name, exp, act);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_stat exp_stat;
        if (!i_rst_n) begin
            pkt_cnt         = '0;
            byte_cnt        = '0;
            frame_cnt       = '0;
            gap_cnt         = '0;
            foreach (type_hist[i]) begin
                type_hist[i] = '0;
            end
            first_t         = '0;
            last_t          = '0;
            frame_start_t   = '0;
            max_spread      = '0;
            last_marker_t   = '0;
            max_marker_gap  = '0;
            cur_frame_stamp = '0;
            prev_seq        = '0;
            in_frame        = 1'b0;
            seq_seen        = 1'b0;
            expected_stats.delete();
            fault_count     = 0;
            result_index    = 0;
            valid_headers   = 0;
            marker_packets  = 0;
        end else begin
            if (i_pkt.valid && i_pkt.ready) begin
                expected_stats.push_back(account_packet(i_pkt.packet_length,
                    i_pkt.header_byte0, i_pkt.header_byte1, i_pkt.sequence_number,
                    i_pkt.rtp_timestamp, i_pkt.arrival_time_us));
            end
            if (i_stat.valid && i_stat.ready) begin
                if (expected_stats.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("result %0d arrived with no packet outstanding", result_index);
                    end
                end else begin
                    exp_stat = expected_stats.pop_front();
                    check_field("total_packets", 64'(exp_stat.total_packets),
                                64'(i_stat.total_packets));
                    check_field("total_bytes", 64'(exp_stat.total_bytes),
                                64'(i_stat.total_bytes));
                    check_field("total_frames", 64'(exp_stat.total_frames),
                                64'(i_stat.total_frames));
                    check_field("total_seq_gaps", 64'(exp_stat.total_seq_gaps),
                                64'(i_stat.total_seq_gaps));
                    check_field("type_packet_count", 64'(exp_stat.type_packet_count),
                                64'(i_stat.type_packet_count));
                    check_field("header_valid", 64'(exp_stat.header_valid),
                                64'(i_stat.header_valid));
                    check_field("max_spread_us", exp_stat.max_spread_us,
                                i_stat.max_spread_us);
                    check_field("peak_marker_gap_us", exp_stat.peak_marker_gap_us,
                                i_stat.peak_marker_gap_us);
                    check_field("first_arrival_us", exp_stat.first_arrival_us,
                                i_stat.first_arrival_us);
                    check_field("last_arrival_us", exp_stat.last_arrival_us,
                                i_stat.last_arrival_us);
                end
                result_index++;
            end
        end
        o_mismatches    <= fault_count;
        o_pending       <= expected_stats.size();
        o_checked       <= result_index;
        o_valid_headers <= valid_headers;
        o_markers       <= marker_packets;
    end

endmodule

@@ dv/tb.sv @@
module tb import rss_pkg::*; ();

    logic i_clk = 1'b0;
    logic i_rst_n;

    rss_in_if  pkt_if ();
    rss_out_if stat_if ();

    int unsigned mismatches;
    int unsigned pending;
    int unsigned checked;
    int unsigned valid_headers;
    int unsigned markers;

    rtp_stream_statistics u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (pkt_if),
        .o_stat  (stat_if)
    );

    rss_stats_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pkt           (pkt_if),
        .i_stat          (stat_if),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_valid_headers (valid_headers),
        .o_markers       (markers)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    int unsigned send_idle;
    int unsigned recv_idle;
    int unsigned sent;

    // state of the well-formed stream
    logic [SEQ_W-1:0]  stream_seq;
    logic [TS_W-1:0]   stream_ts;
    logic [TIME_W-1:0] stream_now;
    logic [PT_W-1:0]   stream_pt;
    bit                allow_backward;

    always @(negedge i_clk) begin
        stat_if.ready <= ($urandom_range(99) >= recv_idle);
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_packet(logic [LEN_W-1:0] len, logic [BYTE_W-1:0] b0,
                               logic [BYTE_W-1:0] b1, logic [SEQ_W-1:0] seq,
                               logic [TS_W-1:0] ts, logic [TIME_W-1:0] now);
        while ($urandom_range(99) < send_idle) begin
            pkt_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pkt_if.valid           <= 1'b1;
        pkt_if.packet_length   <= len;
        pkt_if.header_byte0    <= b0;
        pkt_if.header_byte1    <= b1;
        pkt_if.sequence_number <= seq;
        pkt_if.rtp_timestamp   <= ts;
        pkt_if.arrival_time_us <= now;
        @(posedge i_clk);
        while (!pkt_if.ready) begin
            @(posedge i_clk);
        end
        sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame();
        int unsigned      n;
        int unsigned      roll;
        logic [SEQ_W-1:0] seq_out;
        logic [LEN_W-1:0] len;
        logic             marker;
        n = $urandom_range(1, 6);
        stream_ts = stream_ts + $urandom_range(1, 3000);
        if ($urandom_range(9) == 0) begin
            stream_pt = PT_W'($urandom_range(127));
        end
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(29);
            seq_out = stream_seq;
            case (roll)
                0, 1: begin
                    stream_seq = stream_seq + SEQ_W'($urandom_range(2, 40));
                    seq_out = stream_seq;
                end
                2: seq_out = stream_seq - SEQ_W'(2);
                3: seq_out = stream_seq - SEQ_W'(1);
                default: ;
            endcase
            if (roll != 2 && roll != 3) begin
                stream_seq = seq_out + SEQ_W'(1);
            end
            stream_now = stream_now + TIME_W'($urandom_range(0, 400));
            if (allow_backward && $urandom_range(59) == 0) begin
                stream_now = stream_now - TIME_W'($urandom_range(1, 5000));
            end
            marker = ((k == n - 1) && $urandom_range(7) != 0) || ($urandom_range(19) == 0);
            len = ($urandom_range(19) == 0) ? LEN_W'(17'h10000)
                                            : LEN_W'($urandom_range(12, 1500));
            send_packet(len, {RTP_VERSION, 6'($urandom_range(63))}, {marker, stream_pt},
                        seq_out, stream_ts, stream_now);
        end
        stream_now = stream_now + TIME_W'($urandom_range(100, 20000));
    endtask

    task automatic send_noise();
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] b0;
        logic [TIME_W-1:0] t;
        case ($urandom_range(2))
            0: begin
                len = LEN_W'($urandom_range(0, 11));
                b0  = BYTE_W'($urandom);
                t   = {$urandom, $urandom};
            end
            1: begin
                len = LEN_W'($urandom_range(0, 65536));
                b0  = BYTE_W'($urandom);
                if (b0[7:6] == RTP_VERSION) begin
                    b0[6] = 1'b1;
                end
                t   = {$urandom, $urandom};
            end
            default: begin
                // good header, random content: breaks the sequence
                len = LEN_W'($urandom_range(12, 65536));
                b0  = {RTP_VERSION, 6'($urandom)};
                t   = stream_now;
            end
        endcase
        send_packet(len, b0, BYTE_W'($urandom), SEQ_W'($urandom), $urandom, t);
    endtask

    task automatic run_random(int unsigned count, bit backward);
        int unsigned stop;
        stop = sent + count;
        allow_backward = backward;
        while (sent < stop) begin
            if ($urandom_range(4) == 0) begin
                send_noise();
            end else begin
                send_frame();
            end
        end
    endtask

    initial begin
        i_rst_n                = 1'b0;
        pkt_if.valid           = 1'b0;
        pkt_if.packet_length   = '0;
        pkt_if.header_byte0    = '0;
        pkt_if.header_byte1    = '0;
        pkt_if.sequence_number = '0;
        pkt_if.rtp_timestamp   = '0;
        pkt_if.arrival_time_us = '0;
        stat_if.ready          = 1'b0;
        send_idle              = 21;
        recv_idle              = 84;
        sent                   = 0;
        allow_backward         = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // arrivals at time zero leave the first time unset
        send_packet(LEN_W'(0), 8'h00, 8'h00, 16'h0000, 32'h0000_0000, 64'd0);
        send_packet(LEN_W'(11), 8'h80, 8'h80, 16'hFFFF, 32'hFFFF_FFFF, 64'd0);
        // first good header, then sequence wrap with marker
        send_packet(LEN_W'(12), 8'h80, 8'h00, 16'hFFFF, 32'h0000_0000, 64'd100);
        send_packet(LEN_W'(12), 8'h80, 8'h80, 16'h0000, 32'h0000_0000, 64'd150);
        // wrong versions
        send_packet(LEN_W'(100), 8'hC0, 8'h80, 16'd7, 32'd9, 64'd160);
        send_packet(LEN_W'(100), 8'h40, 8'h80, 16'd7, 32'd9, 64'd170);
        send_packet(LEN_W'(100), 8'h3F, 8'hFF, 16'd7, 32'd9, 64'd180);
        // max length, top payload type, gap of four
        send_packet(LEN_W'(17'h10000), 8'hBF, 8'h7F, 16'd5, 32'hFFFF_FFFF, 64'd200);
        // reorder, then a duplicate that opens and closes a frame at once
        send_packet(LEN_W'(17'h0FFFF), 8'h80, 8'hFF, 16'd3, 32'hFFFF_FFFF, 64'd300);
        send_packet(LEN_W'(40), 8'h80, 8'h81, 16'd3, 32'd1, 64'd320);
        // largest gap that counts, then the smallest that does not
        send_packet(LEN_W'(40), 8'h80, 8'h01, 16'd32770, 32'd2, 64'd400);
        send_packet(LEN_W'(40), 8'h80, 8'h01, 16'd2, 32'd2, 64'd450);
        send_packet(LEN_W'(40), 8'h80, 8'h81, 16'd3, 32'd2, 64'd500);
        send_packet(LEN_W'(1500), 8'h00, 8'h55, 16'hAAAA, 32'h5555_AAAA,
                    64'hFFFF_FFFF_FFFF_FFFF);
        send_packet(LEN_W'(1500), 8'h80, 8'h7F, 16'd4, 32'd10, 64'd600);
        send_packet(LEN_W'(1500), 8'h80, 8'h80, 16'd5, 32'd10, 64'd700);
        // frame closed, same stamp again: new frame start
        send_packet(LEN_W'(1500), 8'h80, 8'h80, 16'd6, 32'd10, 64'd750);

        stream_seq = 16'd7;
        stream_ts  = 32'd10;
        stream_now = 64'd1000;
        stream_pt  = PT_W'(96);

        run_random(180, 1'b0);
        send_idle = 84;
        recv_idle = 21;
        run_random(180, 1'b0);
        send_idle = 0;
        recv_idle = 0;
        run_random(190, 1'b1);
        pkt_if.valid <= 1'b0;

        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        $display("%0d packets driven, %0d results checked", sent, checked);
        $display("%0d with a valid header, %0d marker packets", valid_headers, markers);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
